/* rtl/core/afc_pkg.sv */
// Shared constants and types for the box culling pipeline.
package afc_pkg;

   localparam int COEF_BITS      = 32;
   localparam int COEF_W         = COEF_BITS + 1;
   localparam int DEF_COORD_BITS = 32;
   localparam int DEF_FRAC_BITS  = 16;

   localparam int NUM_REGS      = 8;
   localparam int REG_BITS      = 64;
   localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
   localparam int REG_ADDR_BITS = REG_IDX_BITS + 3;

   localparam int NUM_ROWS   = 4;
   localparam int NUM_AXES   = 3;
   localparam int NUM_TERMS  = 4;
   localparam int NUM_PLANES = 6;

   // Matrix rows by clip-space component; the last term of a row is the offset.
   localparam int ROW_X       = 0;
   localparam int ROW_Y       = 1;
   localparam int ROW_Z       = 2;
   localparam int ROW_W       = 3;
   localparam int TERM_OFFSET = 3;

   // Register stages inside one plane unit: products, axis max, partial sums, sign.
   localparam int PLANE_STAGES = 4;

   typedef enum logic [2:0] {
      PLANE_LEFT,
      PLANE_RIGHT,
      PLANE_BOTTOM,
      PLANE_TOP,
      PLANE_NEAR,
      PLANE_FAR
   } plane_type;

   // Plane function coefficients: three axis terms plus the unscaled offset.
   typedef logic [NUM_TERMS-1:0][COEF_W-1:0] plane_coef_type;

endpackage

/* rtl/core/afc_csr.sv */
// Matrix register file and per-plane coefficient derivation.
module afc_csr
   import afc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [REG_ADDR_BITS-1:0] paddr,
   input  logic [REG_BITS-1:0]      pwdata,
   output logic [REG_BITS-1:0]      prdata,
   output plane_coef_type           plane_coef [NUM_PLANES]
);

   logic [REG_BITS-1:0]     regs_ff [NUM_REGS];
   logic [REG_BITS-1:0]     regs_in [NUM_REGS];
   plane_coef_type          coef_ff [NUM_PLANES];
   plane_coef_type          coef_in [NUM_PLANES];
   logic [COEF_BITS-1:0]    mtx [NUM_ROWS][NUM_TERMS];
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_en;

   function automatic logic [COEF_W-1:0] sx(input logic [COEF_BITS-1:0] v);
      return {v[COEF_BITS-1], v};
   endfunction

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[REG_ADDR_BITS-1:3];
   assign prdata  = regs_ff[reg_idx];

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         regs_in[i] = (wr_en && reg_idx == REG_IDX_BITS'(i)) ? pwdata : regs_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   // Row r: columns 0,1 in register 2r, columns 2,3 in register 2r+1; odd column high.
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_TERMS; c++) begin
            mtx[r][c] = regs_ff[2*r + (c >> 1)][(c & 1)*COEF_BITS +: COEF_BITS];
         end
      end
   end

   // Each plane test is "f < 0" on a linear function of the corner.
   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         for (int t = 0; t < NUM_TERMS; t++) begin
            case (plane_type'(p))
               PLANE_LEFT: begin
                  coef_in[p][t] = sx(mtx[ROW_X][t]) + sx(mtx[ROW_W][t]);
               end
               PLANE_RIGHT: begin
                  coef_in[p][t] = sx(mtx[ROW_W][t]) - sx(mtx[ROW_X][t]);
               end
               PLANE_BOTTOM: begin
                  coef_in[p][t] = sx(mtx[ROW_Y][t]) + sx(mtx[ROW_W][t]);
               end
               PLANE_TOP: begin
                  coef_in[p][t] = sx(mtx[ROW_W][t]) - sx(mtx[ROW_Y][t]);
               end
               PLANE_NEAR: begin
                  coef_in[p][t] = sx(mtx[ROW_Z][t]);
               end
               PLANE_FAR: begin
                  coef_in[p][t] = sx(mtx[ROW_W][t]) - sx(mtx[ROW_Z][t]);
               end
               default: begin
                  coef_in[p][t] = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         coef_ff[p] <= coef_in[p];
      end
   end

   assign plane_coef = coef_ff;

endmodule

/* rtl/core/afc_plane.sv */
// One plane test: max of the plane function over the eight corners, then its sign.
module afc_plane
   import afc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  plane_coef_type               coef,
   input  logic signed [COORD_BITS-1:0] lo [NUM_AXES],
   input  logic signed [COORD_BITS-1:0] hi [NUM_AXES],
   output logic                         all_out
);

   localparam int PROD_W = COEF_W + COORD_BITS;
   localparam int OFS_W  = COEF_W + FRAC_BITS;
   localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

   logic signed [PROD_W-1:0] prod_lo_ff [NUM_AXES];
   logic signed [PROD_W-1:0] prod_lo_in [NUM_AXES];
   logic signed [PROD_W-1:0] prod_hi_ff [NUM_AXES];
   logic signed [PROD_W-1:0] prod_hi_in [NUM_AXES];
   logic signed [SUM_W-1:0]  ofs1_ff;
   logic signed [SUM_W-1:0]  ofs1_in;
   logic signed [PROD_W-1:0] max_ff [NUM_AXES];
   logic signed [PROD_W-1:0] max_in [NUM_AXES];
   logic signed [SUM_W-1:0]  ofs2_ff;
   logic signed [SUM_W-1:0]  part_ff [2];
   logic signed [SUM_W-1:0]  part_in [2];
   logic signed [SUM_W-1:0]  sum;
   logic                     all_out_ff;
   logic                     all_out_in;

   // A linear function over a box peaks at the larger end of every axis term.
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_lo_in[a] = $signed(coef[a]) * lo[a];
         prod_hi_in[a] = $signed(coef[a]) * hi[a];
         max_in[a]     = (prod_hi_ff[a] > prod_lo_ff[a]) ? prod_hi_ff[a] : prod_lo_ff[a];
      end
      ofs1_in    = SUM_W'($signed(coef[TERM_OFFSET])) <<< FRAC_BITS;
      part_in[0] = SUM_W'(max_ff[0]) + SUM_W'(max_ff[1]);
      part_in[1] = SUM_W'(max_ff[2]) + ofs2_ff;
      sum        = part_ff[0] + part_ff[1];
      all_out_in = sum[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      ofs1_ff    <= ofs1_in;
      max_ff     <= max_in;
      ofs2_ff    <= ofs1_ff;
      part_ff    <= part_in;
      all_out_ff <= all_out_in;
   end

   assign all_out = all_out_ff;

endmodule

/* rtl/core/aabb_frustum_cull.sv */
// Throughput: one request per cycle; busy stays low, the six plane units are fully pipelined.
// Stages: input capture, 33x32 products, per-axis max, partial sums, sign, output register.
// Reset clears the matrix registers to zero and drops all requests in flight.
// The receiver cannot stall; a result is on rsp_visible for the single strobe cycle.
module aabb_frustum_cull
   import afc_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_min_x,
   input  logic signed [COORD_BITS-1:0] req_min_y,
   input  logic signed [COORD_BITS-1:0] req_min_z,
   input  logic signed [COORD_BITS-1:0] req_max_x,
   input  logic signed [COORD_BITS-1:0] req_max_y,
   input  logic signed [COORD_BITS-1:0] req_max_z,
   output logic                         rsp_strobe,
   output logic                         rsp_visible,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [REG_ADDR_BITS-1:0]     paddr,
   input  logic [REG_BITS-1:0]          pwdata,
   output logic [REG_BITS-1:0]          prdata,
   output logic                         pready
);

   logic signed [COORD_BITS-1:0] lo_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] lo_in [NUM_AXES];
   logic signed [COORD_BITS-1:0] hi_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] hi_in [NUM_AXES];
   logic [PLANE_STAGES:0]        vld_ff;
   logic [PLANE_STAGES:0]        vld_in;
   logic                         rsp_strobe_ff;
   logic                         rsp_visible_ff;
   logic                         accept;
   logic [NUM_PLANES-1:0]        all_out;
   plane_coef_type               plane_coef [NUM_PLANES];

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start & ~busy;

   afc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .plane_coef (plane_coef)
   );

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      if (accept) begin
         lo_in[0] = req_min_x;
         lo_in[1] = req_min_y;
         lo_in[2] = req_min_z;
         hi_in[0] = req_max_x;
         hi_in[1] = req_max_y;
         hi_in[2] = req_max_z;
      end
      vld_in = {vld_ff[PLANE_STAGES-1:0], accept};
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         rsp_strobe_ff <= vld_ff[PLANE_STAGES];
      end
   end

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      afc_plane #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_plane (
         .clock   (clock),
         .coef    (plane_coef[p]),
         .lo      (lo_ff),
         .hi      (hi_ff),
         .all_out (all_out[p])
      );
   end

   // Culled when every corner is outside any one plane.
   always_ff @(posedge clock) begin
      rsp_visible_ff <= ~|all_out;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

/* rtl/core/afc_check.sv */
// Port-level checks for the culling block, bound to the top level.
module afc_check
   import afc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic                     psel,
   input logic                     penable,
   input logic                     pwrite,
   input logic [REG_ADDR_BITS-1:0] paddr,
   input logic [REG_BITS-1:0]      pwdata,
   input logic [REG_BITS-1:0]      prdata,
   input logic                     pready
);

   localparam int LATENCY = PLANE_STAGES + 2;

   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe)
      else $error("request without result at fixed latency");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without matching request");

   a_readback: assert property (@(posedge clock) disable iff (reset)
      psel && !pwrite && !$past(reset) && $past(psel && penable && pwrite)
         && paddr[REG_ADDR_BITS-1:3] == $past(paddr[REG_ADDR_BITS-1:3])
      |-> prdata == $past(pwdata))
      else $error("register readback differs from written data");

   a_no_wait: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("config port inserted wait state");

endmodule

bind aabb_frustum_cull afc_check u_afc_check (.*);

/* dv/tb_aabb_frustum_cull.sv */
// Testbench for the box culling pipeline: predicts visibility and checks each strobed result.
`timescale 1ns / 100ps

module tb_aabb_frustum_cull;
   import afc_pkg::*;

   localparam int CB   = DEF_COORD_BITS;
   localparam int FB   = DEF_FRAC_BITS;
   localparam int ONE  = 1 << FB;
   localparam int LAT  = 10;

   typedef logic [REG_BITS-1:0] regfile_type [NUM_REGS];

   typedef struct {
      logic signed [CB-1:0] lo [NUM_AXES];
      logic signed [CB-1:0] hi [NUM_AXES];
   } box_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic signed [CB-1:0]      req_min_x = '0, req_min_y = '0, req_min_z = '0;
   logic signed [CB-1:0]      req_max_x = '0, req_max_y = '0, req_max_z = '0;
   logic                      rsp_strobe;
   logic                      rsp_visible;
   logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [REG_ADDR_BITS-1:0]  paddr = '0;
   logic [REG_BITS-1:0]       pwdata = '0;
   logic [REG_BITS-1:0]       prdata;
   logic                      pready;

   regfile_type mtx_q = '{default: '0};
   logic        vis_q [$];
   int          mismatch_count = 0;

   aabb_frustum_cull dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_min_x   (req_min_x),
      .req_min_y   (req_min_y),
      .req_min_z   (req_min_z),
      .req_max_x   (req_max_x),
      .req_max_y   (req_max_y),
      .req_max_z   (req_max_z),
      .rsp_strobe  (rsp_strobe),
      .rsp_visible (rsp_visible),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #800us;
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [REG_BITS-1:0] got,
                                  input logic [REG_BITS-1:0] exp_val);
      $display("%0t: MISMATCH %s: got %h, expected %h", $time, what, got, exp_val);
      mismatch_count++;
   endtask

   // ---------------- visibility predictor ----------------

   function automatic logic signed [31:0] coef_of(int row, int col);
      logic [REG_BITS-1:0] r;
      r = mtx_q[row * 2 + col / 2];
      return (col % 2) ? r[63:32] : r[31:0];
   endfunction

   // exact M[row] . (x, y, z, 1); offset term is scaled up to the product format
   function automatic logic signed [127:0] clip_component(int row, logic signed [CB-1:0] px,
                                                          logic signed [CB-1:0] py,
                                                          logic signed [CB-1:0] pz);
      logic signed [127:0] acc, k, v;
      k = coef_of(row, 0); v = px; acc = k * v;
      k = coef_of(row, 1); v = py; acc = acc + k * v;
      k = coef_of(row, 2); v = pz; acc = acc + k * v;
      k = coef_of(row, TERM_OFFSET);
      acc = acc + (k <<< FB);
      return acc;
   endfunction

   function automatic logic predict_visible(box_type b);
      logic signed [127:0] cx, cy, cz, cw, d;
      logic signed [CB-1:0] px, py, pz;
      logic [NUM_PLANES-1:0] all_out;
      all_out = '1;
      for (int c = 0; c < 8; c++) begin
         px = c[0] ? b.hi[0] : b.lo[0];
         py = c[1] ? b.hi[1] : b.lo[1];
         pz = c[2] ? b.hi[2] : b.lo[2];
         cx = clip_component(ROW_X, px, py, pz);
         cy = clip_component(ROW_Y, px, py, pz);
         cz = clip_component(ROW_Z, px, py, pz);
         cw = clip_component(ROW_W, px, py, pz);
         d = cx + cw; if (!d[127]) all_out[PLANE_LEFT]   = 1'b0;
         d = cw - cx; if (!d[127]) all_out[PLANE_RIGHT]  = 1'b0;
         d = cy + cw; if (!d[127]) all_out[PLANE_BOTTOM] = 1'b0;
         d = cw - cy; if (!d[127]) all_out[PLANE_TOP]    = 1'b0;
         if (!cz[127])             all_out[PLANE_NEAR]   = 1'b0;
         d = cw - cz; if (!d[127]) all_out[PLANE_FAR]    = 1'b0;
      end
      return (all_out == '0);
   endfunction

   // ---------------- result checker ----------------

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (vis_q.size() == 0) begin
            report_mismatch("result with no request pending", REG_BITS'(rsp_visible), '0);
         end else begin
            if (rsp_visible !== vis_q[0])
               report_mismatch("rsp_visible", REG_BITS'(rsp_visible), REG_BITS'(vis_q[0]));
            void'(vis_q.pop_front());
         end
      end
   end

   // ---------------- drivers ----------------

   // write, then read back the same register; the bus goes idle after each transfer
   task automatic csr_write(input int idx, input logic [REG_BITS-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_ADDR_BITS'(idx * 8);
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mtx_q[idx] = val;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== mtx_q[idx])
         report_mismatch($sformatf("readback of register %0d", idx), prdata, mtx_q[idx]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_matrix(input regfile_type regs);
      for (int i = 0; i < NUM_REGS; i++)
         csr_write(i, regs[i]);
   endtask

   task automatic send_box(input box_type b, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start     <= 1'b1;
      req_min_x <= b.lo[0];
      req_min_y <= b.lo[1];
      req_min_z <= b.lo[2];
      req_max_x <= b.hi[0];
      req_max_y <= b.hi[1];
      req_max_z <= b.hi[2];
      do @(posedge clock); while (busy);
      vis_q.push_back(predict_visible(b));
   endtask

   // hold off until every pending request has answered
   task automatic drain_pending();
      start <= 1'b0;
      do @(posedge clock); while (vis_q.size() != 0);
      repeat (LAT) @(posedge clock);
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic box_type mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
      box_type b;
      b.lo[0] = x0; b.lo[1] = y0; b.lo[2] = z0;
      b.hi[0] = x1; b.hi[1] = y1; b.hi[2] = z1;
      return b;
   endfunction

   function automatic int rand_q(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic box_type noise_box();
      return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // small box near the view volume, sometimes with min and max swapped
   function automatic box_type scene_box();
      box_type b;
      int c, h;
      for (int a = 0; a < NUM_AXES; a++) begin
         c = rand_q(3 * ONE);
         h = $urandom_range(0, ONE);
         b.lo[a] = c - h;
         b.hi[a] = c + h;
         if ($urandom_range(0, 9) == 0) begin
            b.lo[a] = c + h;
            b.hi[a] = c - h;
         end
      end
      return b;
   endfunction

   // near-identity transform with perturbed w so that both outcomes are common
   function automatic regfile_type scene_matrix();
      logic signed [31:0] m [NUM_ROWS][NUM_TERMS];
      regfile_type r;
      for (int i = 0; i < NUM_ROWS; i++)
         for (int j = 0; j < NUM_TERMS; j++)
            m[i][j] = rand_q(ONE / 2) + ((i == j) ? ONE : 0);
      for (int i = 0; i < NUM_ROWS; i++) begin
         r[2 * i]     = {m[i][1], m[i][0]};
         r[2 * i + 1] = {m[i][3], m[i][2]};
      end
      return r;
   endfunction

   function automatic regfile_type noise_matrix();
      regfile_type r;
      for (int i = 0; i < NUM_REGS; i++)
         r[i] = {$urandom, $urandom};
      return r;
   endfunction

   // ---------------- tests ----------------

   task automatic test_zero_matrix();
      send_box(mk_box(0, 0, 0, 0, 0, 0), 1'b0);
      send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE), 1'b0);
      send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
      drain_pending();
   endtask

   task automatic test_identity();
      regfile_type id;
      id = '{default: '0};
      id[0] = {32'h0, 32'(ONE)};
      id[2] = {32'(ONE), 32'h0};
      id[5] = {32'h0, 32'(ONE)};
      id[7] = {32'(ONE), 32'h0};
      set_matrix(id);
      send_box(mk_box(-ONE/2, -ONE/2, ONE/4, ONE/2, ONE/2, 3*ONE/4), 1'b0);
      send_box(mk_box(-3*ONE, 0, 0, -2*ONE, 0, 0), 1'b0);           // left
      send_box(mk_box(2*ONE, 0, 0, 3*ONE, 0, 0), 1'b0);             // right
      send_box(mk_box(0, -3*ONE, 0, 0, -2*ONE, 0), 1'b0);           // bottom
      send_box(mk_box(0, 2*ONE, 0, 0, 3*ONE, 0), 1'b0);             // top
      send_box(mk_box(0, 0, -2*ONE, 0, 0, -ONE), 1'b0);             // behind near
      send_box(mk_box(0, 0, 2*ONE, 0, 0, 3*ONE), 1'b0);             // past far
      send_box(mk_box(-3*ONE, -3*ONE, -3*ONE, 3*ONE, 3*ONE, 3*ONE), 1'b0);
      // touching the left plane exactly is not strictly outside
      send_box(mk_box(-2*ONE, 0, 0, -ONE, 0, 0), 1'b0);
      // min above max, both inside and both outside
      send_box(mk_box(ONE/2, ONE/2, ONE/2, -ONE/2, -ONE/2, 0), 1'b0);
      send_box(mk_box(-2*ONE, 0, 0, -3*ONE, 0, 0), 1'b0);
      send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
      send_box(mk_box(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0), 1'b0);
      send_box(mk_box(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0), 1'b0);
      drain_pending();
   endtask

   task automatic test_extreme_matrix();
      logic [REG_BITS-1:0] fills [3];
      fills = '{64'h8000_0000_8000_0000, 64'h7fff_ffff_7fff_ffff, '1};
      foreach (fills[f]) begin
         set_matrix('{default: fills[f]});
         send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0);
         send_box(mk_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                         32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
         drain_pending();
      end
   endtask

   task automatic test_random_stream();
      bit gaps;
      for (int ph = 0; ph < 8; ph++) begin
         gaps = (ph < 7);
         set_matrix((ph % 3 == 2) ? noise_matrix() : scene_matrix());
         for (int n = 0; n < 125; n++) begin
            if (gaps && $urandom_range(0, 39) == 0) begin
               start <= 1'b0;
               do @(posedge clock); while (vis_q.size() != 0);
            end
            send_box(($urandom_range(0, 4) == 0) ? noise_box() : scene_box(), gaps);
         end
         drain_pending();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_matrix();
      test_identity();
      test_extreme_matrix();
      test_random_stream();
      start <= 1'b0;
      while (vis_q.size() != 0) @(posedge clock);
      repeat (LAT) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
rtl/core/afc_pkg.sv
rtl/core/afc_csr.sv
rtl/core/afc_plane.sv
rtl/core/aabb_frustum_cull.sv
rtl/core/afc_check.sv
dv/tb_aabb_frustum_cull.sv
